FILE: hdl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Each macro expands to one labeled concurrent assertion on the rising edge
// of the given clock, disabled while the given reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (c)) \
    else $error("same-cycle check failed");

// Check that a condition implies a consequent in the next cycle.
`define ASSERT_NEXT(lbl, ck, rs, a, c) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (c)) \
    else $error("next-cycle check failed");

`endif

FILE: hdl/dlts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlts_pkg
// Shared types and constants of the delta-list timer scheduler.
// ----------------------------------------------------------------------------
package dlts_pkg;

  localparam int MAX_TASKS_DEF = 16;
  localparam int TICK_MS_DEF   = 10;
  localparam int DATA_W        = 32;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_TICK   = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

endpackage

FILE: hdl/dlts_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlts_cmd_if
// Command channel: add, tick or delete, with valid/ready handshake.
// ----------------------------------------------------------------------------
interface dlts_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [3:0]  task_id;
  logic [31:0] delay_ms;
  logic [31:0] period_ms;

  modport source (output valid, action, task_id, delay_ms, period_ms, input ready);
  modport sink   (input valid, action, task_id, delay_ms, period_ms, output ready);
endinterface

FILE: hdl/dlts_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlts_rsp_if
// Result channel: one transfer per result, with valid/ready handshake.
// ----------------------------------------------------------------------------
interface dlts_rsp_if;
  logic       valid;
  logic       ready;
  logic [3:0] result_id;
  logic       fired;
  logic [1:0] status;
  logic       last;

  modport source (output valid, result_id, fired, status, last, input ready);
  modport sink   (input valid, result_id, fired, status, last, output ready);
endinterface

FILE: hdl/dlts_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlts_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dlts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/delta_list_timer_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_list_timer_scheduler
// Timer queue kept as a sorted delta list in a ring held in block RAM.
// ----------------------------------------------------------------------------
// Operation: an add runs a reciprocal multiply and remainder fix-up alongside
//   the free-id scan, then walks the ring entries and shifts the tail; a delete
//   searches the ring entries and shifts the rest; a tick pops each fired task
//   and walks the ring for each periodic re-insert.
// Throughput: one command at a time; the next is taken after the last result.
// Reset: control state, head, count and id map clear; the RAMs
//   are not cleared and are only read where written.
`include "assert_macros.svh"

module delta_list_timer_scheduler #(
  parameter int MAX_TASKS = dlts_pkg::MAX_TASKS_DEF,
  parameter int TICK_MS   = dlts_pkg::TICK_MS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  dlts_cmd_if.sink   cmd,
  dlts_rsp_if.source rsp
);

  import dlts_pkg::*;

  localparam int IDW  = $clog2(MAX_TASKS);
  localparam int CW   = IDW + 1;
  localparam int IW   = (IDW > 4) ? IDW : 4;
  localparam int RN_W = IDW + DATA_W;
  localparam logic [2*DATA_W-1:0] RECIP_W  = 64'hFFFF_FFFF / 64'(TICK_MS);
  localparam logic [DATA_W-1:0]   RECIP    = RECIP_W[DATA_W-1:0];
  localparam logic [DATA_W-1:0]   TICK_W   = DATA_W'(TICK_MS);
  localparam logic [5:0]          DIV_LAST = 6'd5;

  typedef enum logic [4:0] {
    S_IDLE, S_ADD_DIV, S_EMIT,
    S_TK_RD, S_TK_CHK, S_TK_EMIT, S_TK_PER, S_TK_END,
    S_INS_RD, S_INS_CMP, S_SH_RD, S_SH_WR, S_INS_WR,
    S_DL_RD, S_DL_CMP, S_DS_RD, S_DS_WR
  } state_t;

  state_t state;

  logic [IDW-1:0]      ring_head;
  logic [CW-1:0]       queued_count;
  logic [MAX_TASKS-1:0] id_in_use;

  logic [CW-1:0]     pos, j, scan;
  logic [DATA_W-1:0] rest, dsave, dq, pq;
  logic [DATA_W-1:0] dx, px, drm, prm;
  logic [2*DATA_W-1:0] dprod, pprod;
  logic [5:0]        div_cnt;
  logic              found, dec_done, pend_v, ret_tick;
  logic [IDW-1:0]    cur_id;
  logic [3:0]        pend_id, tid_r, e_id;
  logic              e_fired;
  status_t           e_status;

  logic              o_valid, o_fired, o_last;
  logic [3:0]        o_id;
  status_t           o_status;

  // RAM ports
  logic              ring_we, per_we;
  logic [IDW-1:0]    ring_waddr, ring_raddr, per_waddr, per_raddr;
  logic [RN_W-1:0]   ring_wdata, ring_rdata;
  logic [DATA_W-1:0] per_wdata, per_rdata;

  logic [IDW-1:0]    rd_task;
  logic [DATA_W-1:0] rd_delta, dec_delta;
  logic              do_dec, out_free, div_done, o_load;

  // Ring slot of a position counted from the head
  function automatic logic [IDW-1:0] slot(input logic [IDW-1:0] hd, input logic [CW-1:0] p);
    logic [CW-1:0] s;
    s = CW'(hd) + p;
    if (s >= CW'(MAX_TASKS)) begin
      s = s - CW'(MAX_TASKS);
    end
    return s[IDW-1:0];
  endfunction

  // Task id as a 4-bit result field
  function automatic logic [3:0] to4(input logic [IDW-1:0] id);
    logic [IW-1:0] w;
    w = IW'(id);
    return w[3:0];
  endfunction

  assign rd_task   = ring_rdata[RN_W-1 -: IDW];
  assign rd_delta  = ring_rdata[DATA_W-1:0];
  assign do_dec    = !dec_done && (rd_delta != '0);
  assign dec_delta = do_dec ? rd_delta - 1'b1 : rd_delta;
  assign out_free  = !o_valid || rsp.ready;
  assign div_done  = (div_cnt == DIV_LAST) && (found || scan == CW'(MAX_TASKS));
  assign o_load    = out_free && ((state == S_EMIT) || (state == S_TK_EMIT && pend_v));

  assign cmd.ready     = (state == S_IDLE);
  assign rsp.valid     = o_valid;
  assign rsp.result_id = o_id;
  assign rsp.fired     = o_fired;
  assign rsp.status    = o_status;
  assign rsp.last      = o_last;

  // Drive RAM addresses and writes from the current step
  always_comb begin
    ring_we    = 1'b0;
    ring_waddr = slot(ring_head, pos);
    ring_wdata = {cur_id, rest};
    ring_raddr = slot(ring_head, pos);
    per_we     = 1'b0;
    per_waddr  = scan[IDW-1:0];
    per_wdata  = pq;
    per_raddr  = cur_id;
    case (state)
      S_ADD_DIV: begin
        per_we = div_done && found;
        per_waddr = cur_id;
      end
      S_TK_RD: begin
        ring_raddr = slot(ring_head, '0);
      end
      S_TK_CHK: begin
        ring_we    = do_dec;
        ring_waddr = slot(ring_head, '0);
        ring_wdata = {rd_task, dec_delta};
      end
      S_SH_RD: begin
        ring_raddr = slot(ring_head, j - 1'b1);
      end
      S_SH_WR: begin
        ring_we    = 1'b1;
        ring_waddr = slot(ring_head, j);
        ring_wdata = {rd_task, (j == pos + 1'b1) ? rd_delta - rest : rd_delta};
      end
      S_INS_WR: begin
        ring_we = 1'b1;
      end
      S_DS_RD: begin
        ring_raddr = slot(ring_head, j + 1'b1);
      end
      S_DS_WR: begin
        ring_we    = 1'b1;
        ring_waddr = slot(ring_head, j);
        ring_wdata = {rd_task, (j == pos) ? rd_delta + dsave : rd_delta};
      end
      default: begin
      end
    endcase
  end

  // Sequencer: command decode, walks, shifts and result staging
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      ring_head    <= '0;
      queued_count <= '0;
      id_in_use    <= '0;
      o_valid      <= 1'b0;
      pend_v       <= 1'b0;
    end else begin
      if (o_load) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            e_id     <= '0;
            e_fired  <= 1'b0;
            e_status <= ST_OK;
            case (action_t'(cmd.action))
              ACT_ADD: begin
                dx      <= cmd.delay_ms;
                px      <= cmd.period_ms;
                div_cnt <= '0;
                scan    <= '0;
                found   <= 1'b0;
                if (queued_count >= CW'(MAX_TASKS)) begin
                  e_status <= ST_FULL;
                  state    <= S_EMIT;
                end else begin
                  state <= S_ADD_DIV;
                end
              end
              ACT_TICK: begin
                dec_done <= 1'b0;
                pend_v   <= 1'b0;
                state    <= S_TK_RD;
              end
              ACT_DELETE: begin
                tid_r <= cmd.task_id;
                pos   <= '0;
                state <= S_DL_RD;
              end
              default: begin
                state <= S_EMIT;
              end
            endcase
          end
        end
        // Divide delay and period by the tick length, find the lowest free id
        S_ADD_DIV: begin
          if (div_cnt != DIV_LAST) begin
            div_cnt <= div_cnt + 1'b1;
          end
          case (div_cnt)
            6'd0: begin
              dprod <= {{DATA_W{1'b0}}, dx} * {{DATA_W{1'b0}}, RECIP};
              pprod <= {{DATA_W{1'b0}}, px} * {{DATA_W{1'b0}}, RECIP};
            end
            6'd1: begin
              dq <= dprod[2*DATA_W-1:DATA_W];
              pq <= pprod[2*DATA_W-1:DATA_W];
            end
            6'd2: begin
              drm <= dx - dq * TICK_W;
              prm <= px - pq * TICK_W;
            end
            // Estimate may fall short by up to two; fix up the quotient
            6'd3, 6'd4: begin
              if (drm >= TICK_W) begin
                dq  <= dq + 1'b1;
                drm <= drm - TICK_W;
              end
              if (prm >= TICK_W) begin
                pq  <= pq + 1'b1;
                prm <= prm - TICK_W;
              end
            end
            default: begin
            end
          endcase
          if (!found && scan != CW'(MAX_TASKS)) begin
            if (!id_in_use[scan[IDW-1:0]]) begin
              found  <= 1'b1;
              cur_id <= scan[IDW-1:0];
            end else begin
              scan <= scan + 1'b1;
            end
          end
          if (div_done) begin
            if (!found) begin
              e_status <= ST_FULL;
              state    <= S_EMIT;
            end else begin
              id_in_use[cur_id] <= 1'b1;
              rest     <= dq;
              pos      <= '0;
              ret_tick <= 1'b0;
              state    <= S_INS_RD;
            end
          end
        end
        // Final result of a command
        S_EMIT: begin
          if (out_free) begin
            o_id     <= e_id;
            o_fired  <= e_fired;
            o_status <= e_status;
            o_last   <= 1'b1;
            state    <= S_IDLE;
          end
        end
        // Tick: decrement the head once, then pop every due head entry and re-insert periodic ones
        S_TK_RD: begin
          state <= (queued_count == '0) ? S_TK_END : S_TK_CHK;
        end
        S_TK_CHK: begin
          dec_done <= 1'b1;
          if (dec_delta == '0) begin
            ring_head    <= (ring_head == IDW'(MAX_TASKS - 1)) ? '0 : ring_head + 1'b1;
            queued_count <= queued_count - 1'b1;
            cur_id       <= rd_task;
            state        <= S_TK_EMIT;
          end else begin
            state <= S_TK_END;
          end
        end
        S_TK_EMIT: begin
          if (!pend_v || out_free) begin
            if (pend_v) begin
              o_id     <= pend_id;
              o_fired  <= 1'b1;
              o_status <= ST_OK;
              o_last   <= 1'b0;
            end
            pend_v  <= 1'b1;
            pend_id <= to4(cur_id);
            state   <= S_TK_PER;
          end
        end
        S_TK_PER: begin
          if (per_rdata != '0) begin
            rest     <= per_rdata;
            pos      <= '0;
            ret_tick <= 1'b1;
            state    <= S_INS_RD;
          end else begin
            id_in_use[cur_id] <= 1'b0;
            state <= S_TK_RD;
          end
        end
        S_TK_END: begin
          e_id    <= pend_v ? pend_id : 4'd0;
          e_fired <= pend_v;
          pend_v  <= 1'b0;
          state   <= S_EMIT;
        end
        // Insert: walk the deltas, shift the tail back, write the new entry
        S_INS_RD: begin
          if (pos == queued_count) begin
            j     <= queued_count;
            state <= S_SH_RD;
          end else begin
            state <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (rest >= rd_delta) begin
            rest  <= rest - rd_delta;
            pos   <= pos + 1'b1;
            state <= S_INS_RD;
          end else begin
            j     <= queued_count;
            state <= S_SH_RD;
          end
        end
        S_SH_RD: begin
          state <= (j == pos) ? S_INS_WR : S_SH_WR;
        end
        S_SH_WR: begin
          j     <= j - 1'b1;
          state <= S_SH_RD;
        end
        S_INS_WR: begin
          queued_count <= queued_count + 1'b1;
          if (ret_tick) begin
            state <= S_TK_RD;
          end else begin
            e_id  <= to4(cur_id);
            state <= S_EMIT;
          end
        end
        // Delete: search the ring, then close the gap
        S_DL_RD: begin
          if (pos == queued_count) begin
            e_id     <= tid_r;
            e_status <= ST_NOT_FOUND;
            state    <= S_EMIT;
          end else begin
            state <= S_DL_CMP;
          end
        end
        S_DL_CMP: begin
          if (IW'(rd_task) == IW'(tid_r)) begin
            dsave <= rd_delta;
            j     <= pos;
            state <= S_DS_RD;
          end else begin
            pos   <= pos + 1'b1;
            state <= S_DL_RD;
          end
        end
        S_DS_RD: begin
          if (j + 1'b1 >= queued_count) begin
            queued_count <= queued_count - 1'b1;
            id_in_use[IDW'(tid_r)] <= 1'b0;
            e_id  <= tid_r;
            state <= S_EMIT;
          end else begin
            state <= S_DS_WR;
          end
        end
        S_DS_WR: begin
          j     <= j + 1'b1;
          state <= S_DS_RD;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Ring of {task id, delta ticks}
  dlts_ram #(.WIDTH(RN_W), .DEPTH(MAX_TASKS)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  // Period in ticks per task id
  dlts_ram #(.WIDTH(DATA_W), .DEPTH(MAX_TASKS)) u_period (
    .clk   (clk),
    .we    (per_we),
    .waddr (per_waddr),
    .wdata (per_wdata),
    .raddr (per_raddr),
    .rdata (per_rdata)
  );

  `ASSERT_IMPLIES(a_count_range, clk, rst, 1'b1, queued_count <= CW'(MAX_TASKS))
  `ASSERT_IMPLIES(a_ids_match_count, clk, rst, state == S_IDLE, $countones(id_in_use) == int'(queued_count))
  `ASSERT_NEXT(a_cmd_starts_work, clk, rst, cmd.valid && cmd.ready, state != S_IDLE)
  `ASSERT_IMPLIES(a_fired_ok, clk, rst, o_valid && o_fired, o_status == ST_OK)

endmodule
